// ----- rtl/core/rvalu_pkg.sv -----
// ============================================================================
// rvalu_pkg
// Shared opcodes, status and exception codes, and operand types for the
// RV32I integer ALU execute pipeline.
// ============================================================================
package rvalu_pkg;

  localparam int AGE_BITS_DEF = 7;
  localparam int XLEN         = 32;
  localparam int SHAMT_BITS   = 5;

  localparam logic [SHAMT_BITS-1:0] SHAMT_MASK = 5'h1f;

  localparam logic [3:0] OP_ADD     = 4'd0;
  localparam logic [3:0] OP_AND     = 4'd1;
  localparam logic [3:0] OP_AUIPC   = 4'd2;
  localparam logic [3:0] OP_EBREAK  = 4'd3;
  localparam logic [3:0] OP_ECALL   = 4'd4;
  localparam logic [3:0] OP_FENCE   = 4'd5;
  localparam logic [3:0] OP_FENCE_I = 4'd6;
  localparam logic [3:0] OP_LUI     = 4'd7;
  localparam logic [3:0] OP_OR      = 4'd8;
  localparam logic [3:0] OP_SLL     = 4'd9;
  localparam logic [3:0] OP_SLT     = 4'd10;
  localparam logic [3:0] OP_SLTU    = 4'd11;
  localparam logic [3:0] OP_SRA     = 4'd12;
  localparam logic [3:0] OP_SRL     = 4'd13;
  localparam logic [3:0] OP_SUB     = 4'd14;
  localparam logic [3:0] OP_XOR     = 4'd15;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;

  localparam logic [2:0] EXC_NONE    = 3'd0;
  localparam logic [2:0] EXC_EARLIER = 3'd1;
  localparam logic [2:0] EXC_ILLEGAL = 3'd2;
  localparam logic [2:0] EXC_BREAK   = 3'd3;
  localparam logic [2:0] EXC_ECALL   = 3'd4;

  typedef struct packed {
    logic [3:0]      opcode;
    logic [XLEN-1:0] first_source;
    logic [XLEN-1:0] second_source;
    logic [XLEN-1:0] program_counter;
    logic [XLEN-1:0] immediate_value;
  } alu_uop_t;

endpackage

// ----- rtl/core/rvalu_compute.sv -----
// ============================================================================
// rvalu_compute
// Integer datapath of the execute pipeline: add/sub, logic, shifts,
// set-less-than, lui and auipc.
// ============================================================================
module rvalu_compute
  import rvalu_pkg::*;
(
  input  alu_uop_t        op_in,
  output logic [XLEN-1:0] value
);

  logic [SHAMT_BITS-1:0] shamt;

  assign shamt = op_in.second_source[SHAMT_BITS-1:0] & SHAMT_MASK;

  always_comb begin
    unique case (op_in.opcode)
      OP_ADD:   value = op_in.first_source + op_in.second_source;
      OP_AND:   value = op_in.first_source & op_in.second_source;
      OP_AUIPC: value = op_in.immediate_value + op_in.program_counter;
      OP_LUI:   value = op_in.immediate_value;
      OP_OR:    value = op_in.first_source | op_in.second_source;
      OP_SLL:   value = op_in.first_source << shamt;
      OP_SLT:   value = {{(XLEN-1){1'b0}},
                         ($signed(op_in.first_source) < $signed(op_in.second_source))};
      OP_SLTU:  value = {{(XLEN-1){1'b0}}, (op_in.first_source < op_in.second_source)};
      OP_SRA:   value = $unsigned($signed(op_in.first_source) >>> shamt);
      OP_SRL:   value = op_in.first_source >> shamt;
      OP_SUB:   value = op_in.first_source - op_in.second_source;
      OP_XOR:   value = op_in.first_source ^ op_in.second_source;
      default:  value = '0;
    endcase
  end

endmodule

// ----- rtl/core/rv32i_integer_alu_execute_core.sv -----
// ============================================================================
// rv32i_integer_alu_execute_core
// Execute stage of an RV32I integer ALU: flush filtering, exception
// reporting and the integer datapath in a three-stage pipeline.
// ============================================================================
// Items pass through the stage 1, 2 and 3 registers. Throughput: 1 item per
// cycle unless the output stalls; stages decode/flush, ALU, and result select
// each hold one item, and each advances when the stage after it is free.
// Flushed items are dropped at the first stage and give no result.
// Reset (rst, synchronous): clears the stage valid bits only.
module rv32i_integer_alu_execute_core
  import rvalu_pkg::*;
#(
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,

  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // first_source, second_source, program_counter, immediate_value, item_age,
  // branch_flush, branch_flush_age, store_flush, store_flush_age,
  // commit_flush, zero pad
  input  logic [((4*XLEN+3*AGE_BITS+3+7)/8)*8-1:0] s_axis_tdata,
  // opcode, entry_status
  input  logic [5:0] s_axis_tuser,

  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // result_value
  output logic [XLEN-1:0] m_axis_tdata,
  // exception flag, exception_kind
  output logic [3:0] m_axis_tuser
);

  localparam int AGE_LO   = 4*XLEN;
  localparam int BFL_POS  = AGE_LO + AGE_BITS;
  localparam int BAGE_LO  = BFL_POS + 1;
  localparam int SFL_POS  = BAGE_LO + AGE_BITS;
  localparam int SAGE_LO  = SFL_POS + 1;
  localparam int CFL_POS  = SAGE_LO + AGE_BITS;

  logic [AGE_BITS-1:0] item_age;
  logic [AGE_BITS-1:0] branch_flush_age;
  logic [AGE_BITS-1:0] store_flush_age;
  logic                branch_flush;
  logic                store_flush;
  logic                commit_flush;
  logic [1:0]          entry_status;
  alu_uop_t            in_op;

  assign in_op.first_source    = s_axis_tdata[XLEN-1:0];
  assign in_op.second_source   = s_axis_tdata[2*XLEN-1:XLEN];
  assign in_op.program_counter = s_axis_tdata[3*XLEN-1:2*XLEN];
  assign in_op.immediate_value = s_axis_tdata[4*XLEN-1:3*XLEN];
  assign in_op.opcode          = s_axis_tuser[3:0];
  assign entry_status          = s_axis_tuser[5:4];
  assign item_age              = s_axis_tdata[AGE_LO +: AGE_BITS];
  assign branch_flush          = s_axis_tdata[BFL_POS];
  assign branch_flush_age      = s_axis_tdata[BAGE_LO +: AGE_BITS];
  assign store_flush           = s_axis_tdata[SFL_POS];
  assign store_flush_age       = s_axis_tdata[SAGE_LO +: AGE_BITS];
  assign commit_flush          = s_axis_tdata[CFL_POS];

  // stage handshake
  logic v1, v2, v3;
  logic ready1, ready2, ready3;
  logic in_fire;

  assign ready3        = !v3 || m_axis_tready;
  assign ready2        = !v2 || ready3;
  assign ready1        = !v1 || ready2;
  assign s_axis_tready = ready1;
  assign in_fire       = s_axis_tvalid && ready1;

  // stage 1: flush check and exception decode
  logic       drop;
  logic [2:0] kind_next;

  assign drop = commit_flush
             || (branch_flush && (item_age > branch_flush_age))
             || (store_flush && (item_age >= store_flush_age));

  always_comb begin
    priority if (entry_status[1]) begin
      kind_next = EXC_EARLIER;
    end else if (entry_status == ST_INVALID) begin
      kind_next = EXC_ILLEGAL;
    end else if (in_op.opcode == OP_EBREAK) begin
      kind_next = EXC_BREAK;
    end else if (in_op.opcode == OP_ECALL) begin
      kind_next = EXC_ECALL;
    end else begin
      kind_next = EXC_NONE;
    end
  end

  alu_uop_t   op1;
  logic [2:0] kind1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_fire && !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op1   <= in_op;
      kind1 <= kind_next;
    end
  end

  // stage 2: integer datapath
  logic [XLEN-1:0] alu_value;
  logic [XLEN-1:0] value2;
  logic [2:0]      kind2;

  rvalu_compute u_compute (
    .op_in (op1),
    .value (alu_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      value2 <= alu_value;
      kind2  <= kind1;
    end
  end

  // stage 3: result select and output register
  logic [XLEN-1:0] value3;
  logic [2:0]      kind3;
  logic            exc3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      value3 <= (kind2 != EXC_NONE) ? '0 : value2;
      kind3  <= kind2;
      exc3   <= (kind2 != EXC_NONE);
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = value3;
  assign m_axis_tuser  = {kind3, exc3};

  // checks
  a_exc_flag_matches_kind: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (exc3 == (kind3 != EXC_NONE)))
    else $error("exception flag disagrees with exception kind");

  a_exc_zero_value: assert property (@(posedge clk) disable iff (rst)
    (v3 && exc3) |-> (value3 == '0))
    else $error("nonzero result with exception");

  a_commit_flush_drops: assert property (@(posedge clk) disable iff (rst)
    (in_fire && commit_flush) |=> !v1)
    else $error("commit-flushed item entered the pipeline");

  a_stall_keeps_result: assert property (@(posedge clk) disable iff (rst)
    (v3 && !m_axis_tready) |=> v3)
    else $error("stalled result lost");

endmodule
